// ===== rtl/msie_pkg.sv =====
// Package for the MIPS subset executor: payload structs, opcode and funct
// codes, register indexes and storage sizes. No dependencies.
`default_nettype none

package msie_pkg;

  // Storage sizes
  localparam int DATA_WORDS = 4096;
  localparam int DATA_AW    = $clog2(DATA_WORDS);
  localparam int NUM_REGS   = 32;
  localparam int REG_AW     = 5;

  // Reset values
  localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;

  // Configuration register indexes
  localparam logic CFG_TEXT_BASE      = 1'b0;
  localparam logic CFG_PROGRAM_LENGTH = 1'b1;

  // Request kinds
  localparam logic REQ_EXECUTE = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL funct codes; anything else runs as subu
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Link register for jal
  localparam logic [REG_AW-1:0] REG_LINK = 5'd31;
  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;

  // Input request payload
  typedef struct packed {
    logic        req_type;
    logic [31:0] instruction_word;
    logic [11:0] preload_index;
    logic [31:0] preload_value;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        store_done;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic        halted;
  } res_t;

  // Register file write port
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [31:0]       data;
  } rf_wr_t;

  // Data memory access request
  typedef struct packed {
    logic               we;
    logic               re;
    logic [DATA_AW-1:0] addr;
    logic [31:0]        wdata;
  } mem_req_t;

  // Execute stage output
  typedef struct packed {
    res_t     res;
    logic     load;
    mem_req_t mem;
  } exec_t;

endpackage

`default_nettype wire

// ===== rtl/msie_regfile.sv =====
// 32 x 32 general register file, two registered read ports, one write port.
// Depends on msie_pkg. Reset clears per-entry valid bits; invalid reads 0.
`default_nettype none

module msie_regfile (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [msie_pkg::REG_AW-1:0] ra,
  input  wire logic [msie_pkg::REG_AW-1:0] rb,
  input  wire msie_pkg::rf_wr_t          wr,
  output logic [31:0]                    rda,
  output logic [31:0]                    rdb
);

  logic [31:0]                   mem [msie_pkg::NUM_REGS];
  logic [msie_pkg::NUM_REGS-1:0] vld;
  logic [31:0]                   ra_q;
  logic [31:0]                   rb_q;
  logic                          va_q;
  logic                          vb_q;

  // valid bits: cleared at reset, set on first write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  // storage and registered reads (read sees value before this edge's write)
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    ra_q <= mem[ra];
    rb_q <= mem[rb];
    va_q <= vld[ra];
    vb_q <= vld[rb];
  end

  assign rda = va_q ? ra_q : 32'd0;
  assign rdb = vb_q ? rb_q : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/msie_dmem.sv =====
// Word-addressed data memory, single port, registered read data.
// Depends on msie_pkg. Runs a zeroing sweep after reset, one word a cycle.
`default_nettype none

module msie_dmem (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire msie_pkg::mem_req_t req,
  output logic [31:0]             rdata,
  output logic                    busy
);

  logic [31:0]                  mem [msie_pkg::DATA_WORDS];
  logic [msie_pkg::DATA_AW-1:0] clr_cnt;
  logic                         clr_last;

  assign clr_last = (clr_cnt == msie_pkg::DATA_AW'(msie_pkg::DATA_WORDS - 1));

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + msie_pkg::DATA_AW'(1);
      if (clr_last) begin
        busy <= 1'b0;
      end
    end
  end

  // storage: sweep writes zero, otherwise one access per cycle
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= 32'd0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msie_exec.sv =====
// Execute logic: decode, ALU, branch/jump target, PC clamp, memory request.
// Depends on msie_pkg. Purely combinational; operands arrive forwarded.
`default_nettype none

module msie_exec (
  input  wire msie_pkg::req_t req,
  input  wire logic [31:0]    pc,
  input  wire logic [31:0]    text_end,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  output msie_pkg::exec_t     ex
);

  always_comb begin
    logic [31:0] w;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] seq;
    logic [31:0] sum;
    logic [31:0] npc;

    w    = req.instruction_word;
    op   = w[31:26];
    rt   = w[20:16];
    rd   = w[15:11];
    sh   = w[10:6];
    fn   = w[5:0];
    zimm = {16'd0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    seq  = pc + 32'd4;
    sum  = a + simm;
    npc  = seq;

    ex               = '0;
    ex.mem.addr      = sum[2 +: msie_pkg::DATA_AW];
    ex.mem.wdata     = b;

    // decode and compute
    case (op)
      msie_pkg::OP_SPECIAL: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rd;
        case (fn)
          msie_pkg::FN_AND:  ex.res.dest_value = a & b;
          msie_pkg::FN_ADDU: ex.res.dest_value = a + b;
          msie_pkg::FN_JR: begin
            ex.res.reg_written = 1'b0;
            ex.res.dest_index  = msie_pkg::REG_ZERO;
            npc                = a;
          end
          msie_pkg::FN_NOR:  ex.res.dest_value = ~(a | b);
          msie_pkg::FN_OR:   ex.res.dest_value = a | b;
          msie_pkg::FN_SLTU: ex.res.dest_value = (a < b) ? 32'd1 : 32'd0;
          msie_pkg::FN_SLL:  ex.res.dest_value = b << sh;
          msie_pkg::FN_SRL:  ex.res.dest_value = b >> sh;
          default:           ex.res.dest_value = a - b;
        endcase
      end
      msie_pkg::OP_J: begin
        npc = {seq[31:28], w[25:0], 2'b00};
      end
      msie_pkg::OP_JAL: begin
        npc                = {seq[31:28], w[25:0], 2'b00};
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = msie_pkg::REG_LINK;
        ex.res.dest_value  = pc + 32'd8;
      end
      msie_pkg::OP_ADDIU: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.res.dest_value  = sum;
      end
      msie_pkg::OP_ANDI: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.res.dest_value  = a & zimm;
      end
      msie_pkg::OP_ORI: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.res.dest_value  = a | zimm;
      end
      msie_pkg::OP_SLTIU: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.res.dest_value  = (a < simm) ? 32'd1 : 32'd0;
      end
      msie_pkg::OP_LUI: begin
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.res.dest_value  = {w[15:0], 16'd0};
      end
      msie_pkg::OP_LW: begin
        // value arrives from memory one stage later
        ex.res.reg_written = 1'b1;
        ex.res.dest_index  = rt;
        ex.load            = 1'b1;
      end
      msie_pkg::OP_SW: begin
        ex.res.store_done    = 1'b1;
        ex.res.store_address = sum;
        ex.res.store_value   = b;
        ex.mem.we            = 1'b1;
      end
      msie_pkg::OP_BEQ: begin
        if (a == b) begin
          npc = seq + {simm[29:0], 2'b00};
        end
      end
      msie_pkg::OP_BNE: begin
        if (a != b) begin
          npc = seq + {simm[29:0], 2'b00};
        end
      end
      default: begin
      end
    endcase

    // writes to register zero are dropped
    if (ex.res.reg_written && ex.res.dest_index == msie_pkg::REG_ZERO) begin
      ex.res.reg_written = 1'b0;
      ex.res.dest_value  = 32'd0;
      ex.load            = 1'b0;
    end
    ex.mem.re = ex.load;

    // clamp at end of text
    if (npc > text_end) begin
      npc = text_end;
    end

    // preload: one memory write, PC untouched
    if (req.req_type == msie_pkg::REQ_PRELOAD) begin
      ex           = '0;
      npc          = pc;
      ex.mem.we    = 1'b1;
      ex.mem.addr  = req.preload_index[msie_pkg::DATA_AW-1:0];
      ex.mem.wdata = req.preload_value;
    end

    ex.res.next_pc = npc;
    ex.res.halted  = (npc >= text_end);
  end

endmodule

`default_nettype wire

// ===== rtl/mips_subset_instruction_executor_top.sv =====
// Top level of the MIPS subset executor: handshakes, config registers, PC,
// pipeline registers and operand forwarding. Depends on msie_pkg,
// msie_regfile, msie_dmem and msie_exec.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------
//   request | in        | in_valid / in_stall | in_req  (msie_pkg::req_t)
//   result  | out       | out_valid/out_stall | out_res (msie_pkg::res_t)
//   config  | in        | cfg_en              | cfg_index, cfg_data
//
// One request per clock while out_stall is low and the sweep is done; a result
// passes the execute and memory/write-back stages and the output register.
// Register reads are registered and patched by forwarding from the
// write-back stage and from the write made at the previous edge.
// After rst the data memory is swept to zero over all DATA_WORDS (4096)
// words; in_stall stays high meanwhile, config writes still land.
// out_stall backs up through both stages to in_stall in the same cycle.
`default_nettype none

module mips_subset_instruction_executor_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire msie_pkg::req_t in_req,
  output logic                out_valid,
  input  wire logic           out_stall,
  output msie_pkg::res_t      out_res,
  input  wire logic           cfg_en,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);

  // configuration and architectural PC
  logic [31:0]         text_base;
  logic [16:0]         program_length;
  logic [31:0]         text_end;
  logic [31:0]         pc;

  // pipeline state
  logic                s1_v;
  msie_pkg::req_t      s1;
  logic                s2_v;
  msie_pkg::res_t      s2_res;
  logic                s2_load;
  logic                out_v;
  msie_pkg::res_t      out_q;

  // flow control
  logic                out_free;
  logic                s2_free;
  logic                s2_go;
  logic                s1_free;
  logic                s1_go;
  logic                accept;

  // datapath
  logic [31:0]         rd_word;
  logic [31:0]         rf_a;
  logic [31:0]         rf_b;
  logic [31:0]         op_a;
  logic [31:0]         op_b;
  logic [31:0]         s2_val;
  msie_pkg::res_t      s2_out;
  logic [31:0]         dm_rdata;
  logic                dm_busy;
  msie_pkg::rf_wr_t    rf_wr;
  msie_pkg::rf_wr_t    wb_q;
  msie_pkg::exec_t     ex;
  msie_pkg::mem_req_t  mem_req;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_base      <= msie_pkg::TEXT_BASE_RESET;
      program_length <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        msie_pkg::CFG_TEXT_BASE:      text_base      <= cfg_data;
        msie_pkg::CFG_PROGRAM_LENGTH: program_length <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  assign text_end = text_base + {13'd0, program_length, 2'b00};

  // stage advance chain
  assign out_free = !out_v || !out_stall;
  assign s2_go    = s2_v && out_free;
  assign s2_free  = !s2_v || out_free;
  assign s1_go    = s1_v && s2_free;
  assign s1_free  = !s1_v || s2_free;
  assign in_stall = !s1_free || dm_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= accept;
      end
      if (s2_free) begin
        s2_v <= s1_v;
      end
      if (out_free) begin
        out_v <= s2_v;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_req;
    end
    if (s1_go) begin
      s2_res  <= ex.res;
      s2_load <= ex.load;
    end
    if (s2_go) begin
      out_q <= s2_out;
    end
  end

  // PC moves when an execute request leaves the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= msie_pkg::TEXT_BASE_RESET;
    end else if (s1_go && s1.req_type == msie_pkg::REQ_EXECUTE) begin
      pc <= ex.res.next_pc;
    end
  end

  // register reads target whatever sits in the execute stage next cycle
  assign rd_word = s1_free ? in_req.instruction_word : s1.instruction_word;

  msie_regfile u_regfile (
    .clk (clk),
    .rst (rst),
    .ra  (rd_word[25:21]),
    .rb  (rd_word[20:16]),
    .wr  (rf_wr),
    .rda (rf_a),
    .rdb (rf_b)
  );

  // write-back from stage 2; remember last edge's write for forwarding
  assign s2_val      = s2_load ? dm_rdata : s2_res.dest_value;
  assign rf_wr.en    = s2_go && s2_res.reg_written;
  assign rf_wr.idx   = s2_res.dest_index;
  assign rf_wr.data  = s2_val;

  // result leaving stage 2, load data merged in
  always_comb begin
    s2_out            = s2_res;
    s2_out.dest_value = s2_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_q.en <= 1'b0;
    end else begin
      wb_q.en <= rf_wr.en;
    end
    wb_q.idx  <= rf_wr.idx;
    wb_q.data <= rf_wr.data;
  end

  // operand forwarding: stage 2 first, then last written value
  always_comb begin
    if (s2_v && s2_res.reg_written && s2_res.dest_index == s1.instruction_word[25:21]) begin
      op_a = s2_val;
    end else if (wb_q.en && wb_q.idx == s1.instruction_word[25:21]) begin
      op_a = wb_q.data;
    end else begin
      op_a = rf_a;
    end
    if (s2_v && s2_res.reg_written && s2_res.dest_index == s1.instruction_word[20:16]) begin
      op_b = s2_val;
    end else if (wb_q.en && wb_q.idx == s1.instruction_word[20:16]) begin
      op_b = wb_q.data;
    end else begin
      op_b = rf_b;
    end
  end

  msie_exec u_exec (
    .req      (s1),
    .pc       (pc),
    .text_end (text_end),
    .a        (op_a),
    .b        (op_b),
    .ex       (ex)
  );

  // memory access happens as the request leaves the execute stage
  always_comb begin
    mem_req    = ex.mem;
    mem_req.we = ex.mem.we && s1_go;
    mem_req.re = ex.mem.re && s1_go;
  end

  msie_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  assign out_valid = out_v;
  assign out_res   = out_q;

  // register zero is never written
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> rf_wr.idx != msie_pkg::REG_ZERO)
    else $error("register zero written");

  // no memory traffic from requests while the clearing sweep runs
  a_no_mem_in_clear: assert property (@(posedge clk) disable iff (rst)
    dm_busy |-> !(mem_req.we || mem_req.re))
    else $error("memory access during clearing sweep");

  // a request leaving stage 2 shows up as a valid result
  a_s2_to_out: assert property (@(posedge clk) disable iff (rst)
    s2_go |=> out_valid)
    else $error("stage 2 request lost");

  // PC changes only when an execute request leaves the execute stage
  a_pc_update: assert property (@(posedge clk) disable iff (rst)
    (pc != $past(pc)) |-> $past(s1_go && s1.req_type == msie_pkg::REQ_EXECUTE))
    else $error("PC changed without an executed request");

endmodule

`default_nettype wire

// ===== tb/tb_mips_subset_instruction_executor_top.sv =====
// Self-checking bench for the MIPS subset executor: drives requests, config
// writes and result stalls, and predicts every result from its own model of
// registers, PC and data memory. Depends on msie_pkg and the top level RTL.
module tb_mips_subset_instruction_executor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msie_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Instruction kinds drawn by the random generator
  typedef enum int {
    K_SLL, K_SRL, K_JR, K_AND, K_ADDU, K_NOR, K_OR, K_SLTU, K_SUBU, K_J, K_JAL,
    K_ADDIU, K_ANDI, K_BEQ, K_BNE, K_LUI, K_LW, K_ORI, K_SLTIU, K_SW, K_COUNT
  } instr_kind_e;

  // Architectural model of the executor plus the queue of results it predicts
  class mips_result_tracker;
    logic [31:0] gpr [NUM_REGS];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] pc;
    logic [31:0] text_base;
    logic [16:0] prog_len;
    res_t        expected_results[$];
    int          errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc        = TEXT_BASE_RESET;
      text_base = TEXT_BASE_RESET;
      prog_len  = '0;
      errors    = 0;
    endfunction

    function void write_config(logic idx, logic [31:0] data);
      if (idx == CFG_TEXT_BASE) begin
        text_base = data;
      end else begin
        prog_len = data[16:0];
      end
    endfunction

    // Execute one accepted request and queue the result it must produce
    function void note_request(req_t r);
      res_t        e;
      logic [31:0] w, a, b, zimm, simm, seq, npc, text_end, addr;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh;
      e = '0;
      text_end = text_base + {13'b0, prog_len, 2'b00};
      if (r.req_type == REQ_PRELOAD) begin
        dmem[r.preload_index] = r.preload_value;
      end else begin
        w    = r.instruction_word;
        op   = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        sh   = w[10:6];
        fn   = w[5:0];
        zimm = {16'b0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        a    = gpr[rs];
        b    = gpr[rt];
        seq  = pc + 32'd4;
        npc  = seq;
        case (op)
          OP_SPECIAL: begin
            e.reg_written = 1'b1;
            e.dest_index  = rd;
            case (fn)
              FN_AND:  e.dest_value = a & b;
              FN_ADDU: e.dest_value = a + b;
              FN_JR: begin
                e.reg_written = 1'b0;
                e.dest_index  = REG_ZERO;
                npc = a;
              end
              FN_NOR:  e.dest_value = ~(a | b);
              FN_OR:   e.dest_value = a | b;
              FN_SLTU: e.dest_value = {31'b0, a < b};
              FN_SLL:  e.dest_value = b << sh;
              FN_SRL:  e.dest_value = b >> sh;
              default: e.dest_value = a - b;
            endcase
          end
          OP_J, OP_JAL: begin
            npc = {seq[31:28], w[25:0], 2'b00};
            if (op == OP_JAL) begin
              e.reg_written = 1'b1;
              e.dest_index  = REG_LINK;
              e.dest_value  = pc + 32'd8;
            end
          end
          OP_ADDIU: begin
            e.reg_written = 1'b1; e.dest_index = rt; e.dest_value = a + simm;
          end
          OP_ANDI: begin
            e.reg_written = 1'b1; e.dest_index = rt; e.dest_value = a & zimm;
          end
          OP_ORI: begin
            e.reg_written = 1'b1; e.dest_index = rt; e.dest_value = a | zimm;
          end
          OP_SLTIU: begin
            e.reg_written = 1'b1; e.dest_index = rt; e.dest_value = {31'b0, a < simm};
          end
          OP_LUI: begin
            e.reg_written = 1'b1; e.dest_index = rt; e.dest_value = zimm << 16;
          end
          OP_LW: begin
            addr = a + simm;
            e.reg_written = 1'b1;
            e.dest_index  = rt;
            e.dest_value  = dmem[addr[DATA_AW+1:2]];
          end
          OP_SW: begin
            addr = a + simm;
            e.store_done    = 1'b1;
            e.store_address = addr;
            e.store_value   = b;
            dmem[addr[DATA_AW+1:2]] = b;
          end
          OP_BEQ: if (a == b) npc = seq + (simm << 2);
          OP_BNE: if (a != b) npc = seq + (simm << 2);
          default: ;
        endcase
        // register zero swallows the write
        if (e.reg_written && e.dest_index == REG_ZERO) begin
          e.reg_written = 1'b0;
          e.dest_value  = '0;
        end
        if (e.reg_written) gpr[e.dest_index] = e.dest_value;
        if (npc > text_end) npc = text_end;
        pc = npc;
      end
      e.next_pc = pc;
      e.halted  = (pc >= text_end);
      expected_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual %h", $time, got);
        return;
      end
      e = expected_results.pop_front();
      compare_field("next_pc", e.next_pc, got.next_pc);
      compare_field("reg_written", 32'(e.reg_written), 32'(got.reg_written));
      compare_field("dest_index", 32'(e.dest_index), 32'(got.dest_index));
      compare_field("dest_value", e.dest_value, got.dest_value);
      compare_field("store_done", 32'(e.store_done), 32'(got.store_done));
      compare_field("store_address", e.store_address, got.store_address);
      compare_field("store_value", e.store_value, got.store_value);
      compare_field("halted", 32'(e.halted), 32'(got.halted));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        out_res;
  logic        cfg_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  bit          calm = 1'b0;        // when set, neither side idles
  logic [31:0] cur_base = TEXT_BASE_RESET;
  int          cycle_count = 0;
  mips_result_tracker tracker = new();

  mips_subset_instruction_executor_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result checking at every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_res);
  end

  // Result side: random stall before each result
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Instruction encoders
  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // Mostly the low registers so values chain between instructions
  function automatic logic [4:0] pick_reg();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 5'($urandom_range(0, 7));
    if (roll == 7) return REG_LINK;
    return 5'($urandom());
  endfunction

  function automatic logic [15:0] pick_imm();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 16'($urandom_range(0, 255));
    if (roll < 5) begin
      case ($urandom_range(0, 3))
        0: return 16'h0000;
        1: return 16'h7FFF;
        2: return 16'h8000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom());
  endfunction

  // One random request: mostly valid program instructions, some preloads and raw words
  function automatic req_t make_request();
    req_t        r;
    int          roll;
    instr_kind_e k;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm;
    logic [25:0] tgt;
    r.req_type         = REQ_EXECUTE;
    r.instruction_word = $urandom();
    r.preload_index    = 12'($urandom());
    r.preload_value    = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.req_type = REQ_PRELOAD;
      if ($urandom_range(0, 1)) r.preload_index = 12'($urandom_range(0, 63));
      return r;
    end
    if (roll < 14) return r;
    k   = instr_kind_e'($urandom_range(0, K_COUNT - 1));
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    imm = pick_imm();
    tgt = 26'((cur_base >> 2) + $urandom_range(0, 300));
    if ($urandom_range(0, 7) == 0) tgt = 26'($urandom());
    case (k)
      K_SLL:  r.instruction_word = r_word(rs, rt, rd, 5'($urandom()), FN_SLL);
      K_SRL:  r.instruction_word = r_word(rs, rt, rd, 5'($urandom()), FN_SRL);
      K_JR: begin
        if ($urandom_range(0, 3) != 0) rs = REG_LINK;
        r.instruction_word = r_word(rs, REG_ZERO, REG_ZERO, 5'd0, FN_JR);
      end
      K_AND:  r.instruction_word = r_word(rs, rt, rd, 5'd0, FN_AND);
      K_ADDU: r.instruction_word = r_word(rs, rt, rd, 5'd0, FN_ADDU);
      K_NOR:  r.instruction_word = r_word(rs, rt, rd, 5'd0, FN_NOR);
      K_OR:   r.instruction_word = r_word(rs, rt, rd, 5'd0, FN_OR);
      K_SLTU: r.instruction_word = r_word(rs, rt, rd, 5'd0, FN_SLTU);
      K_SUBU: r.instruction_word = r_word(rs, rt, rd, 5'($urandom()), 6'($urandom()));
      K_J:    r.instruction_word = j_word(OP_J, tgt);
      K_JAL:  r.instruction_word = j_word(OP_JAL, tgt);
      K_ADDIU: r.instruction_word = i_word(OP_ADDIU, rs, rt, imm);
      K_ANDI:  r.instruction_word = i_word(OP_ANDI, rs, rt, imm);
      K_ORI:   r.instruction_word = i_word(OP_ORI, rs, rt, imm);
      K_SLTIU: r.instruction_word = i_word(OP_SLTIU, rs, rt, imm);
      K_LUI:   r.instruction_word = i_word(OP_LUI, rs, rt, imm);
      K_BEQ, K_BNE: begin
        if ($urandom_range(0, 2) == 0) rt = rs;
        if ($urandom_range(0, 3) != 0) begin
          imm = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                     : -16'($urandom_range(1, 40));
        end
        r.instruction_word = i_word(k == K_BEQ ? OP_BEQ : OP_BNE, rs, rt, imm);
      end
      default: begin
        // loads and stores, often at small word-aligned addresses off r0
        if ($urandom_range(0, 1)) rs = REG_ZERO;
        if ($urandom_range(0, 1)) imm = 16'($urandom_range(0, 63) * 4);
        r.instruction_word = i_word(k == K_LW ? OP_LW : OP_SW, rs, rt, imm);
      end
    endcase
    return r;
  endfunction

  // Present one request after a random gap and wait until it is taken
  task automatic send_request(req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(r);
  endtask

  task automatic send_word(logic [31:0] w);
    req_t r;
    r = make_request();
    r.req_type = REQ_EXECUTE;
    r.instruction_word = w;
    send_request(r);
  endtask

  task automatic send_preload(logic [11:0] idx, logic [31:0] value);
    req_t r;
    r = make_request();
    r.req_type = REQ_PRELOAD;
    r.preload_index = idx;
    r.preload_value = value;
    send_request(r);
  endtask

  task automatic write_config(logic idx, logic [31:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_config(idx, data);
  endtask

  // Wait until every predicted result came back, then let the pipe settle
  task automatic drain();
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_program(logic [31:0] base, logic [16:0] len);
    drain();
    write_config(CFG_TEXT_BASE, base);
    write_config(CFG_PROGRAM_LENGTH, {15'b0, len});
    cfg_en   <= 1'b0;
    cur_base = base;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      send_request(make_request());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every operation, extension and zero-register rules
    set_program(TEXT_BASE_RESET, 17'd65536);
    send_preload(12'd0, 32'hFFFF_FFFF);
    send_preload(12'd4095, 32'h8000_0001);
    send_word(i_word(OP_LUI, REG_ZERO, 5'd1, 16'hFFFF));
    send_word(i_word(OP_ORI, 5'd1, 5'd1, 16'hFFFF));        // zero-extended
    send_word(i_word(OP_ADDIU, REG_ZERO, 5'd2, 16'h8000));  // sign-extended
    send_word(i_word(OP_ANDI, 5'd1, 5'd3, 16'h8000));
    send_word(i_word(OP_SLTIU, REG_ZERO, 5'd4, 16'hFFFF));  // 0 < 0xffffffff
    send_word(i_word(OP_SLTIU, 5'd1, 5'd5, 16'h0001));
    send_word(r_word(5'd1, 5'd4, 5'd6, 5'd0, FN_ADDU));     // wraps to zero
    send_word(r_word(REG_ZERO, 5'd4, 5'd7, 5'd0, 6'h23));   // unlisted funct, subu
    send_word(r_word(5'd1, 5'd2, 5'd8, 5'd0, FN_AND));
    send_word(r_word(5'd3, 5'd4, 5'd9, 5'd0, FN_OR));
    send_word(r_word(REG_ZERO, REG_ZERO, 5'd10, 5'd0, FN_NOR));
    send_word(r_word(5'd4, 5'd1, 5'd11, 5'd0, FN_SLTU));
    send_word(r_word(REG_ZERO, 5'd4, 5'd12, 5'd31, FN_SLL));
    send_word(r_word(REG_ZERO, 5'd1, 5'd13, 5'd31, FN_SRL));
    send_word(i_word(OP_ADDIU, 5'd1, REG_ZERO, 16'd5));     // write to r0 dropped
    send_word(i_word(OP_SW, 5'd4, 5'd1, 16'hFFFC));         // negative offset
    send_word(i_word(OP_LW, REG_ZERO, 5'd14, 16'h0000));
    send_word(i_word(OP_LW, REG_ZERO, 5'd15, 16'h3FFC));    // top data word
    send_word(i_word(OP_BEQ, REG_ZERO, REG_ZERO, 16'd2));   // taken
    send_word(i_word(OP_BNE, REG_ZERO, REG_ZERO, 16'd5));   // not taken
    send_word(j_word(OP_JAL, 26'h010_0008));
    send_word(r_word(REG_LINK, REG_ZERO, REG_ZERO, 5'd0, FN_JR));
    send_word(j_word(OP_J, 26'h3FF_FFFF));                  // past text end, halts
    send_word(32'hFFFF_FFFF);                               // unknown opcode

    // Random phases across program layouts, extremes included
    run_random(250);
    set_program(32'h0040_0000, 17'd32);
    run_random(200);
    set_program(32'h0000_0000, 17'd0);
    run_random(100);
    set_program(32'hFFFF_FFFC, 17'd65536);  // text end wraps past zero
    run_random(150);
    set_program(32'hFFFF_FFFF, 17'd1);
    run_random(100);
    set_program(32'h0000_1000, 17'd256);
    run_random(200);

    drain();
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
